FILE: rtl/online_load_table_macros.svh
// assertion helpers for the load table, clocked on clock, held off in reset
`ifndef ONLINE_LOAD_TABLE_MACROS_SVH
`define ONLINE_LOAD_TABLE_MACROS_SVH

// same-cycle implication
`define OLT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define OLT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/olt_pkg.sv
// ----------------------------------------------------------------------------
// olt_pkg
// types, codes and constants shared by the load table modules
// ----------------------------------------------------------------------------
package olt_pkg;

   localparam int DEPTH_DEF = 16;
   localparam int PWR_W     = 24;
   localparam int ID_W      = 8;
   localparam int LIM_W     = 23;
   localparam int OCC_W     = 5;
   localparam int ST_W      = 3;
   localparam int CSR_W     = 23;

   localparam logic signed [PWR_W-1:0] PWR_MAX = 24'sh7FFFFF;
   localparam logic signed [PWR_W-1:0] PWR_MIN = -24'sh800000;
   localparam logic [LIM_W-1:0] LIMIT_RST = 23'd800;

   // result status codes
   localparam logic [ST_W-1:0] ST_IGNORED  = 3'd0;
   localparam logic [ST_W-1:0] ST_UPDATED  = 3'd1;
   localparam logic [ST_W-1:0] ST_REMOVED  = 3'd2;
   localparam logic [ST_W-1:0] ST_INSERTED = 3'd3;
   localparam logic [ST_W-1:0] ST_EVICTED  = 3'd4;

   // request kinds
   localparam logic KIND_EVENT = 1'b0;
   localparam logic KIND_SET   = 1'b1;

   // register indexes
   localparam logic REG_NULL_ID = 1'b0;
   localparam logic REG_LOW_PWR = 1'b1;

   typedef struct packed {
      logic                    kind;
      logic signed [ID_W-1:0]  entry_id;
      logic signed [PWR_W-1:0] power_value;
      logic signed [PWR_W-1:0] given_peak;
   } req_type;

   typedef struct packed {
      logic [ST_W-1:0]         status;
      logic signed [ID_W-1:0]  result_id;
      logic signed [PWR_W-1:0] entry_power;
      logic signed [PWR_W-1:0] entry_peak;
      logic signed [ID_W-1:0]  evicted_id;
      logic [OCC_W-1:0]        occupancy;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE, S_SEARCH, S_UPDATE, S_COMMIT, S_SHIFT, S_APPEND, S_FINISH
   } state_type;

   typedef struct packed {
      logic load;      // capture request
      logic scan;      // search step
      logic shift;     // compaction step
      logic upd;       // compute updated entry
      logic wr_pos;    // write updated entry back
      logic cstart;    // start compaction behind hit
      logic estart;    // start compaction for eviction
      logic dec;       // count down
      logic app;       // append new entry
      logic ign;       // ignored result
      logic fin;       // load output register
   } cmd_type;

   typedef struct packed {
      logic ign_id;
      logic hit;
      logic miss;
      logic neg_pv;
      logic full;
      logic rm;
      logic upd_ign;
      logic shift_done;
      logic evict;
      logic out_free;
   } stat_type;

endpackage

FILE: rtl/online_load_table.sv
// ----------------------------------------------------------------------------
// online_load_table
// ordered table of active loads keyed by id, with power tracking
// ----------------------------------------------------------------------------
// One request is worked at a time. A request first scans the entry memory
// oldest first, one entry a cycle with the read pipelined. An update then
// passes through S_UPDATE and S_COMMIT, and a removal or an eviction
// compacts the list entry by entry behind the affected slot on the
// single-port-write memory. The result sits in an output register, so the
// next request is taken while it waits. Table contents need no clearing
// pass: only entries below the fill count are read.
module online_load_table
   import olt_pkg::*;
#(
   parameter int TABLE_DEPTH = DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   // request channel
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_payload,
   // result channel
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_payload,
   // register writes
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [CSR_W-1:0] csr_wdata
);

`include "online_load_table_macros.svh"

   cmd_type  cmd;
   stat_type stat;
   logic     idle;

   // sequencer
   olt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .stat      (stat),
      .cmd       (cmd),
      .idle      (idle)
   );

   // memory and arithmetic
   olt_dp #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cmd         (cmd),
      .rsp_stall   (rsp_stall),
      .stat        (stat),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   // busy from acceptance until the result is loaded
   assign req_stall = !idle;

   `OLT_ASSERT_NEXT(a_busy_after_req, req_valid && !req_stall, req_stall,
      "request accepted but block not busy")
   `OLT_ASSERT_NOW(a_ignored_zero, rsp_valid && rsp_payload.status == ST_IGNORED,
      rsp_payload.entry_power == '0 && rsp_payload.evicted_id == '0,
      "ignored result carries data")
   `OLT_ASSERT_NOW(a_evict_full, rsp_valid && rsp_payload.status == ST_EVICTED,
      rsp_payload.occupancy == OCC_W'(TABLE_DEPTH),
      "eviction with table not full")

endmodule

FILE: rtl/olt_ctrl.sv
// ----------------------------------------------------------------------------
// olt_ctrl
// sequencer for search, update, compaction and append
// ----------------------------------------------------------------------------
module olt_ctrl
   import olt_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  stat_type stat,
   output cmd_type  cmd,
   output logic     idle
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      idle     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            idle = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            if (stat.ign_id) begin
               cmd.ign  = 1'b1;
               state_in = S_FINISH;
            end else begin
               cmd.scan = 1'b1;
               if (stat.hit) begin
                  state_in = S_UPDATE;
               end else if (stat.miss) begin
                  if (stat.neg_pv) begin
                     cmd.ign  = 1'b1;
                     state_in = S_FINISH;
                  end else if (stat.full) begin
                     cmd.estart = 1'b1;
                     state_in   = S_SHIFT;
                  end else begin
                     state_in = S_APPEND;
                  end
               end
            end
         end
         S_UPDATE: begin
            cmd.upd  = 1'b1;
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            if (stat.upd_ign) begin
               state_in = S_FINISH;
            end else if (stat.rm) begin
               cmd.cstart = 1'b1;
               state_in   = S_SHIFT;
            end else begin
               cmd.wr_pos = 1'b1;
               state_in   = S_FINISH;
            end
         end
         S_SHIFT: begin
            cmd.shift = 1'b1;
            if (stat.shift_done) begin
               cmd.dec  = 1'b1;
               state_in = stat.evict ? S_APPEND : S_FINISH;
            end
         end
         S_APPEND: begin
            cmd.app  = 1'b1;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (stat.out_free) begin
               cmd.fin  = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

FILE: rtl/olt_dp.sv
// ----------------------------------------------------------------------------
// olt_dp
// entry memory, scan pointer, update arithmetic and output register
// ----------------------------------------------------------------------------
module olt_dp
   import olt_pkg::*;
#(
   parameter int TABLE_DEPTH = DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  req_type          req_payload,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [CSR_W-1:0] csr_wdata,
   input  cmd_type          cmd,
   input  logic             rsp_stall,
   output stat_type         stat,
   output logic             rsp_valid,
   output rsp_type          rsp_payload
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int EW = ID_W + 2 * PWR_W;

   logic [EW-1:0] mem [TABLE_DEPTH];
   logic [EW-1:0] rd_q_ff;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [EW-1:0] wr_data;
   logic          wr_en;

   logic signed [ID_W-1:0]  null_id_ff;
   logic [LIM_W-1:0]        low_lim_ff;
   req_type                 req_ff;
   logic [CW-1:0]           count_ff, idx_ff, pidx_ff;
   logic                    pend_ff, ev_ff;
   logic [AW-1:0]           pos_ff;
   logic signed [PWR_W-1:0] epow_ff, epeak_ff;
   logic signed [ID_W-1:0]  first_ff;
   logic [ST_W-1:0]         rst_ff;
   logic signed [PWR_W-1:0] rpow_ff, rpeak_ff;
   logic signed [ID_W-1:0]  revict_ff;
   logic                    rm_ff;
   rsp_type                 out_ff;
   logic                    outv_ff;

   logic signed [ID_W-1:0]  rd_id;
   logic signed [PWR_W-1:0] rd_pow, rd_peak;
   logic                    can_read, hit;
   logic signed [PWR_W:0]   sum;
   logic signed [PWR_W-1:0] np, npeak, speak;
   logic signed [PWR_W+3:0] np10;
   logic                    rm_c;

   assign {rd_id, rd_pow, rd_peak} = rd_q_ff;
   assign can_read = (idx_ff < count_ff);
   assign rd_addr  = idx_ff[AW-1:0];
   assign hit      = pend_ff && (rd_id == req_ff.entry_id);

   // memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_q_ff <= mem[rd_addr];
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = pos_ff;
      wr_data = {req_ff.entry_id, rpow_ff, rpeak_ff};
      if (cmd.shift && pend_ff) begin
         wr_en   = 1'b1;
         wr_addr = AW'(pidx_ff - CW'(1));
         wr_data = rd_q_ff;
      end else if (cmd.wr_pos) begin
         wr_en = 1'b1;
      end else if (cmd.app) begin
         wr_en   = 1'b1;
         wr_addr = count_ff[AW-1:0];
         wr_data = {req_ff.entry_id, req_ff.power_value, req_ff.power_value};
      end
   end

   // update arithmetic
   always_comb begin
      sum  = {epow_ff[PWR_W-1], epow_ff} + {req_ff.power_value[PWR_W-1], req_ff.power_value};
      if (sum > 25'sd8388607) begin
         np = PWR_MAX;
      end else if (sum < -25'sd8388608) begin
         np = PWR_MIN;
      end else begin
         np = sum[PWR_W-1:0];
      end
      npeak = (np > epeak_ff) ? np : epeak_ff;
      speak = (req_ff.given_peak > epow_ff) ? req_ff.given_peak : epow_ff;
      np10  = (28'(np) <<< 3) + (28'(np) <<< 1);
      rm_c  = ($signed({np[PWR_W-1], np}) < $signed({2'b00, low_lim_ff}))
              || (np10 < 28'(epow_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         null_id_ff <= '0;
         low_lim_ff <= LIMIT_RST;
         count_ff   <= '0;
         pend_ff    <= 1'b0;
         outv_ff    <= 1'b0;
      end else begin
         if (csr_we) begin
            if (csr_index == REG_NULL_ID) begin
               null_id_ff <= csr_wdata[ID_W-1:0];
            end else begin
               low_lim_ff <= csr_wdata[LIM_W-1:0];
            end
         end
         if (cmd.load || cmd.estart || cmd.cstart) begin
            pend_ff <= 1'b0;
         end else if (cmd.scan || cmd.shift) begin
            pend_ff <= can_read;
         end
         if (cmd.dec) begin
            count_ff <= count_ff - CW'(1);
         end else if (cmd.app) begin
            count_ff <= count_ff + CW'(1);
         end
         if (cmd.fin) begin
            outv_ff <= 1'b1;
         end else if (!rsp_stall) begin
            outv_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_payload;
         idx_ff <= '0;
         ev_ff  <= 1'b0;
      end else if (cmd.estart) begin
         idx_ff <= CW'(1);
         ev_ff  <= 1'b1;
      end else if (cmd.cstart) begin
         idx_ff <= CW'(pos_ff) + CW'(1);
      end else if ((cmd.scan || cmd.shift) && can_read) begin
         idx_ff <= idx_ff + CW'(1);
      end
      if ((cmd.scan || cmd.shift) && can_read) begin
         pidx_ff <= idx_ff;
      end
      if (cmd.scan && hit) begin
         pos_ff   <= pidx_ff[AW-1:0];
         epow_ff  <= rd_pow;
         epeak_ff <= rd_peak;
      end
      if (cmd.scan && pend_ff && (pidx_ff == '0)) begin
         first_ff <= rd_id;
      end
      if (cmd.upd) begin
         revict_ff <= '0;
         rm_ff     <= 1'b0;
         if (req_ff.kind == KIND_EVENT) begin
            rpow_ff  <= np;
            rpeak_ff <= npeak;
            rm_ff    <= rm_c;
            rst_ff   <= rm_c ? ST_REMOVED : ST_UPDATED;
         end else if (req_ff.power_value[PWR_W-1]) begin
            rpow_ff  <= '0;
            rpeak_ff <= '0;
            rst_ff   <= ST_IGNORED;
         end else begin
            rpow_ff  <= req_ff.power_value;
            rpeak_ff <= speak;
            rst_ff   <= ST_UPDATED;
         end
      end else if (cmd.ign) begin
         rst_ff    <= ST_IGNORED;
         rpow_ff   <= '0;
         rpeak_ff  <= '0;
         revict_ff <= '0;
      end else if (cmd.app) begin
         rst_ff    <= ev_ff ? ST_EVICTED : ST_INSERTED;
         rpow_ff   <= req_ff.power_value;
         rpeak_ff  <= req_ff.power_value;
         revict_ff <= ev_ff ? first_ff : '0;
      end
      if (cmd.fin) begin
         out_ff.status      <= rst_ff;
         out_ff.result_id   <= req_ff.entry_id;
         out_ff.entry_power <= rpow_ff;
         out_ff.entry_peak  <= rpeak_ff;
         out_ff.evicted_id  <= revict_ff;
         out_ff.occupancy   <= OCC_W'(count_ff);
      end
   end

   always_comb begin
      stat            = '0;
      stat.ign_id     = (req_ff.entry_id <= null_id_ff);
      stat.hit        = hit;
      stat.miss       = !pend_ff && !can_read;
      stat.neg_pv     = req_ff.power_value[PWR_W-1];
      stat.full       = (count_ff == CW'(TABLE_DEPTH));
      stat.rm         = rm_ff;
      stat.upd_ign    = (rst_ff == ST_IGNORED);
      stat.shift_done = !pend_ff && !can_read;
      stat.evict      = ev_ff;
      stat.out_free   = !outv_ff || !rsp_stall;
   end

   assign rsp_valid   = outv_ff;
   assign rsp_payload = out_ff;

endmodule

FILE: verif/online_load_table_tb.sv
// ----------------------------------------------------------------------------
// online_load_table_tb
// self-checking bench for the ordered load table
// ----------------------------------------------------------------------------
// A short table of directed requests (extremes, ignored ids, saturation, a
// direct set, removals) and a fill past the depth are followed by random
// requests in several register settings. Each request runs through a local
// copy; each response is checked field by field with the oldest prediction.
module online_load_table_tb;
   import olt_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH       = DEPTH_DEF;
   localparam int CYCLE_LIMIT = 400000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   req_type          req_payload = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   rsp_type          rsp_payload;
   logic             csr_we = 1'b0;
   logic             csr_index = REG_NULL_ID;
   logic [CSR_W-1:0] csr_wdata = '0;

   online_load_table #(.TABLE_DEPTH(DEPTH)) i_dut (
      .clock, .reset,
      .req_valid, .req_stall, .req_payload,
      .rsp_valid, .rsp_stall, .rsp_payload,
      .csr_we, .csr_index, .csr_wdata
   );

   // period 12 ns
   initial begin
      forever #6 clock = ~clock;
   end

   // local copy of the table and its registers
   int load_id [DEPTH];
   int load_pwr [DEPTH];
   int load_peak [DEPTH];
   int load_cnt = 0;
   int null_lim = 0;
   int low_lim  = 800;

   rsp_type pending_rsp [$];
   bit      quiet = 1'b0;       // no idling on either side while set
   int      n_errors = 0;
   int      n_req = 0, n_rsp = 0, n_removed = 0, n_evicted = 0, n_ignored = 0;
   int      cycles = 0;

   // close the gap behind a slot, oldest entries stay in front
   function automatic void drop_slot(int pos);
      for (int j = pos; j < load_cnt - 1; j++) begin
         load_id[j]   = load_id[j+1];
         load_pwr[j]  = load_pwr[j+1];
         load_peak[j] = load_peak[j+1];
      end
      load_cnt--;
   endfunction

   // response for one request, updating the local table
   function automatic rsp_type predict_load(req_type r);
      rsp_type o;
      int      id, pv, gp, pos, prev, np;
      longint  sum;
      bit      hit;
      o = '0;
      o.result_id = r.entry_id;
      id = r.entry_id;
      pv = r.power_value;
      gp = r.given_peak;
      pos = 0;
      hit = 1'b0;
      if (id > null_lim) begin
         for (int i = 0; i < load_cnt; i++)
            if (!hit && load_id[i] == id) begin
               pos = i;
               hit = 1'b1;
            end
         if (hit && r.kind == KIND_EVENT) begin
            prev = load_pwr[pos];
            sum = longint'(prev) + longint'(pv);
            // saturating accumulate
            if (sum > 64'sd8388607) np = 8388607;
            else if (sum < -64'sd8388608) np = -8388608;
            else np = int'(sum);
            load_pwr[pos] = np;
            if (np > load_peak[pos]) load_peak[pos] = np;
            o.entry_power = np;
            o.entry_peak = load_peak[pos];
            // below the limit or below a tenth of the old power
            if (np < low_lim || longint'(np) * 10 < longint'(prev)) begin
               drop_slot(pos);
               o.status = ST_REMOVED;
            end else begin
               o.status = ST_UPDATED;
            end
         end else if (hit) begin
            if (pv >= 0) begin
               load_peak[pos] = (gp > load_pwr[pos]) ? gp : load_pwr[pos];
               load_pwr[pos] = pv;
               o.entry_power = pv;
               o.entry_peak = load_peak[pos];
               o.status = ST_UPDATED;
            end
         end else if (pv >= 0) begin
            o.status = ST_INSERTED;
            if (load_cnt >= DEPTH) begin
               o.evicted_id = load_id[0];
               drop_slot(0);
               o.status = ST_EVICTED;
            end
            load_id[load_cnt] = id;
            load_pwr[load_cnt] = pv;
            load_peak[load_cnt] = pv;
            load_cnt++;
            o.entry_power = pv;
            o.entry_peak = pv;
         end
      end
      o.occupancy = load_cnt[OCC_W-1:0];
      return o;
   endfunction

   // hand one request over, with a random idle gap in front of it
   task automatic send_request(req_type r, bit known, rsp_type typed);
      rsp_type p;
      if (!quiet && $urandom_range(0, 99) < 23) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (req_stall);
      p = predict_load(r);
      // directed rows with a typed-in answer use it instead
      pending_rsp.push_back(known ? typed : p);
      n_req++;
   endtask

   // both registers, idle block only; holds the old values until written
   task automatic set_limits(int nid, int lowp);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (2 * DEPTH + 16) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= REG_NULL_ID;
      csr_wdata <= CSR_W'(nid[7:0]);
      @(posedge clock);
      csr_index <= REG_LOW_PWR;
      csr_wdata <= CSR_W'(lowp);
      @(posedge clock);
      csr_we <= 1'b0;
      null_lim = nid;
      low_lim = lowp;
   endtask

   // random request, ids mostly from a small pool so entries get hit again
   function automatic req_type random_request();
      req_type r;
      r.kind = $urandom_range(0, 99) < 30 ? KIND_SET : KIND_EVENT;
      if ($urandom_range(0, 99) < 85) r.entry_id = ID_W'($urandom_range(1, 22));
      else r.entry_id = ID_W'($urandom);
      case ($urandom_range(0, 9))
         0: r.power_value = PWR_MAX;
         1: r.power_value = PWR_MIN;
         2, 3: r.power_value = PWR_W'($urandom);
         4, 5: r.power_value = -PWR_W'($urandom_range(0, 4000));
         6: r.power_value = PWR_W'($urandom_range(0, 8388607));
         default: r.power_value = PWR_W'($urandom_range(0, 6000));
      endcase
      r.given_peak = ($urandom_range(0, 1)) ? PWR_W'($urandom)
                                            : PWR_W'($urandom_range(0, 9000));
      return r;
   endfunction

   // response side: random stall and the compare against the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_rsp.size() == 0) begin
               $error("unexpected response, id %0d", rsp_payload.result_id);
               n_errors++;
            end else begin
               want = pending_rsp.pop_front();
               n_rsp++;
               if (want.status == ST_REMOVED) n_removed++;
               if (want.status == ST_EVICTED) n_evicted++;
               if (want.status == ST_IGNORED) n_ignored++;
               if (rsp_payload.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_payload.status);
                  n_errors++;
               end
               if (rsp_payload.result_id !== want.result_id) begin
                  $error("result_id: expected %0d, got %0d",
                         want.result_id, rsp_payload.result_id);
                  n_errors++;
               end
               if (rsp_payload.entry_power !== want.entry_power) begin
                  $error("entry_power: expected %0d, got %0d",
                         want.entry_power, rsp_payload.entry_power);
                  n_errors++;
               end
               if (rsp_payload.entry_peak !== want.entry_peak) begin
                  $error("entry_peak: expected %0d, got %0d",
                         want.entry_peak, rsp_payload.entry_peak);
                  n_errors++;
               end
               if (rsp_payload.evicted_id !== want.evicted_id) begin
                  $error("evicted_id: expected %0d, got %0d",
                         want.evicted_id, rsp_payload.evicted_id);
                  n_errors++;
               end
               if (rsp_payload.occupancy !== want.occupancy) begin
                  $error("occupancy: expected %0d, got %0d",
                         want.occupancy, rsp_payload.occupancy);
                  n_errors++;
               end
            end
         end
         rsp_stall <= !quiet && ($urandom_range(0, 99) < 23);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("online_load_table_tb: errors");
         $finish;
      end
   end

   typedef struct {
      req_type r;
      bit      known;
      rsp_type e;
   } stim_row;

   // directed requests, answers typed in where they are obvious
   stim_row dir_rows [] = '{
      // first insert into an empty table
      '{'{KIND_EVENT, 8'sd5, 24'sd1000, 24'sd0}, 1'b1,
        '{ST_INSERTED, 8'sd5, 24'sd1000, 24'sd1000, 8'sd0, 5'd1}},
      // id at the null limit, and the most negative id
      '{'{KIND_EVENT, 8'sd0, 24'sd50, 24'sd0}, 1'b1,
        '{ST_IGNORED, 8'sd0, 24'sd0, 24'sd0, 8'sd0, 5'd1}},
      '{'{KIND_SET, -8'sd128, PWR_MAX, PWR_MAX}, 1'b1,
        '{ST_IGNORED, -8'sd128, 24'sd0, 24'sd0, 8'sd0, 5'd1}},
      // unlisted id with negative power
      '{'{KIND_EVENT, 8'sd127, -24'sd5, 24'sd0}, 1'b1,
        '{ST_IGNORED, 8'sd127, 24'sd0, 24'sd0, 8'sd0, 5'd1}},
      '{'{KIND_EVENT, 8'sd127, PWR_MAX, PWR_MIN}, 1'b1,
        '{ST_INSERTED, 8'sd127, PWR_MAX, PWR_MAX, 8'sd0, 5'd2}},
      // saturation at the top
      '{'{KIND_EVENT, 8'sd127, PWR_MAX, 24'sd0}, 1'b0, '0},
      // direct set on a listed id with negative power
      '{'{KIND_SET, 8'sd5, -24'sd1, 24'sd0}, 1'b1,
        '{ST_IGNORED, 8'sd5, 24'sd0, 24'sd0, 8'sd0, 5'd2}},
      '{'{KIND_SET, 8'sd5, 24'sd2000, 24'sd500}, 1'b0, '0},
      '{'{KIND_SET, 8'sd5, 24'sd3000, PWR_MAX}, 1'b0, '0},
      // falls under the low limit
      '{'{KIND_EVENT, 8'sd5, -24'sd2850, 24'sd0}, 1'b0, '0},
      // most negative power on an entry at the top, removed
      '{'{KIND_EVENT, 8'sd127, PWR_MIN, 24'sd0}, 1'b0, '0},
      // zero power insert, then a drop below a tenth
      '{'{KIND_SET, 8'sd9, 24'sd0, PWR_MIN}, 1'b0, '0},
      '{'{KIND_EVENT, 8'sd20, 24'sd100000, 24'sd0}, 1'b0, '0},
      '{'{KIND_EVENT, 8'sd20, -24'sd91000, 24'sd0}, 1'b0, '0},
      '{'{KIND_EVENT, 8'sd21, 24'sd5000, 24'sd0}, 1'b0, '0},
      '{'{KIND_EVENT, 8'sd21, 24'sd1000, 24'sd0}, 1'b0, '0},
      '{'{KIND_EVENT, 8'sd21, -24'sd100, 24'sd0}, 1'b0, '0},
      '{'{KIND_EVENT, 8'sd9, PWR_MIN, 24'sd0}, 1'b0, '0}
   };

   // stimulus
   initial begin
      int lims [5][2] = '{'{0, 800}, '{-128, 0}, '{10, 8388607},
                          '{127, 1}, '{-1, 23'h2AAAAA}};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[k]) send_request(dir_rows[k].r, dir_rows[k].known, dir_rows[k].e);

      // fill past the depth to force evictions, no idling here
      quiet = 1'b1;
      for (int k = 0; k < DEPTH + 4; k++) begin
         req_type f;
         f = '{KIND_EVENT, ID_W'(30 + k), PWR_W'(1000 + k), '0};
         send_request(f, 1'b0, '0);
      end
      quiet = 1'b0;

      for (int ph = 0; ph < 5; ph++) begin
         set_limits(lims[ph][0], lims[ph][1]);
         // third phase runs with no idling on either side
         quiet = (ph == 2);
         for (int k = 0; k < (ph == 3 ? 30 : 110); k++)
            send_request(random_request(), 1'b0, '0);
      end
      quiet = 1'b0;
      req_valid <= 1'b0;

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (2 * DEPTH + 16) @(posedge clock);
      $display("%0d requests over 5 limit settings, %0d responses checked", n_req, n_rsp);
      $display("%0d removals, %0d evictions, %0d ignored", n_removed, n_evicted, n_ignored);
      if (n_errors == 0) begin
         $display("online_load_table_tb: clean");
      end else begin
         $display("online_load_table_tb: errors");
      end
      $finish;
   end

endmodule
